@@ design/rmob_pkg.sv @@
// Shared types, register indexes and constants for the RGB565 masked overlay blender.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package rmob_pkg;

	localparam int CANVAS_W_DEF = 256;
	localparam int CANVAS_H_DEF = 256;

	localparam int ADDR_W = 5;
	localparam int POS_W = 18;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_WIDTH = 3'd2;
	localparam logic [2:0] REG_HEIGHT = 3'd3;
	localparam logic [2:0] REG_USE_MASK = 3'd4;

	localparam logic [3:0] ALPHA_CLEAR = 4'h0;
	localparam logic [3:0] ALPHA_OPAQUE = 4'hF;

	// 65536 / 15 rounded up; exact for every blend sum up to 63 * 15.
	localparam logic [12:0] RECIP15 = 13'd4370;

	typedef struct packed {
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [15:0] overlay_width;
		logic [15:0] overlay_height;
		logic        use_mask;
	} cfg_t;

	typedef struct packed {
		logic [15:0]      src_color;
		logic [7:0]       mask_byte;
		logic [15:0]      dst_color;
		logic             col_odd;
		logic [POS_W-1:0] dx;
		logic [POS_W-1:0] dy;
		logic             last;
	} item_t;

	typedef struct packed {
		logic        write_enable;
		logic [15:0] dst_addr;
		logic [15:0] pixel;
	} result_t;

	function automatic logic [5:0] blend_chan(input logic [5:0] s, input logic [5:0] d,
		input logic [3:0] a);
		logic [9:0]  sum;
		logic [23:0] prod;
		sum = 10'(s) * 10'(a) + 10'(d) * 10'(ALPHA_OPAQUE - a);
		prod = 24'(sum) * 24'(RECIP15);
		return prod[21:16];
	endfunction

endpackage
`default_nettype wire

@@ design/rmob_regs.sv @@
// Configuration register file on the APB port: origin, overlay size and mask enable.
// Depends on rmob_pkg for the register indexes and the configuration struct.
`default_nettype none
module rmob_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [rmob_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output rmob_pkg::cfg_t                 cfg
);
	import rmob_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx = paddr[4:2];
	assign wr = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= 16'd0;
			cfg_q.origin_y <= 16'd0;
			cfg_q.overlay_width <= 16'd1;
			cfg_q.overlay_height <= 16'd1;
			cfg_q.use_mask <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				REG_ORIGIN_X: cfg_q.origin_x <= pwdata[15:0];
				REG_ORIGIN_Y: cfg_q.origin_y <= pwdata[15:0];
				REG_WIDTH: cfg_q.overlay_width <= pwdata[15:0];
				REG_HEIGHT: cfg_q.overlay_height <= pwdata[15:0];
				REG_USE_MASK: cfg_q.use_mask <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ORIGIN_X: prdata = {16'd0, cfg_q.origin_x};
			REG_ORIGIN_Y: prdata = {16'd0, cfg_q.origin_y};
			REG_WIDTH: prdata = {16'd0, cfg_q.overlay_width};
			REG_HEIGHT: prdata = {16'd0, cfg_q.overlay_height};
			REG_USE_MASK: prdata = {31'd0, cfg_q.use_mask};
			default: prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

@@ design/rmob_pos.sv @@
// Overlay column and row counters with the canvas position of the current pixel.
// Depends on rmob_pkg for the configuration struct and position width.
`default_nettype none
module rmob_pos (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire rmob_pkg::cfg_t           cfg,
	input  wire logic                     advance,
	output logic                          col_odd,
	output logic [rmob_pkg::POS_W-1:0]    dx,
	output logic [rmob_pkg::POS_W-1:0]    dy,
	output logic                          ovl_end
);
	import rmob_pkg::*;

	logic [15:0] col_q;
	logic [15:0] row_q;
	logic [15:0] w_eff;
	logic [15:0] h_eff;
	logic        row_end;

	// A size of zero behaves as one.
	assign w_eff = (cfg.overlay_width == 16'd0) ? 16'd1 : cfg.overlay_width;
	assign h_eff = (cfg.overlay_height == 16'd0) ? 16'd1 : cfg.overlay_height;

	assign row_end = ({1'b0, col_q} + 17'd1) >= {1'b0, w_eff};
	assign ovl_end = row_end && (({1'b0, row_q} + 17'd1) >= {1'b0, h_eff});

	assign col_odd = col_q[0];
	assign dx = {{(POS_W-16){cfg.origin_x[15]}}, cfg.origin_x} + POS_W'(col_q);
	assign dy = {{(POS_W-16){cfg.origin_y[15]}}, cfg.origin_y} + POS_W'(row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 16'd0;
			row_q <= 16'd0;
		end else if (advance) begin
			if (row_end) begin
				col_q <= 16'd0;
				row_q <= ovl_end ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + 16'd1;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/rmob_blend.sv @@
// Clipping, alpha selection, per-channel blend and canvas address for one pixel.
// Purely combinational; depends on rmob_pkg for the item, result and blend function.
`default_nettype none
module rmob_blend #(
	parameter int CANVAS_W = rmob_pkg::CANVAS_W_DEF,
	parameter int CANVAS_H = rmob_pkg::CANVAS_H_DEF
) (
	input  wire rmob_pkg::item_t item,
	input  wire logic         use_mask,
	output rmob_pkg::result_t res
);
	import rmob_pkg::*;

	localparam logic [POS_W-2:0] CW = (POS_W-1)'(CANVAS_W);
	localparam logic [POS_W-2:0] CH = (POS_W-1)'(CANVAS_H);

	logic        inside_x;
	logic        inside_y;
	logic [3:0]  alpha;
	logic [31:0] index;
	logic [4:0]  r;
	logic [5:0]  g;
	logic [4:0]  b;
	logic [5:0]  r6;
	logic [5:0]  b6;

	assign inside_x = !item.dx[POS_W-1] && (item.dx[POS_W-2:0] < CW);
	assign inside_y = !item.dy[POS_W-1] && (item.dy[POS_W-2:0] < CH);

	assign alpha = !use_mask ? ALPHA_OPAQUE :
		(item.col_odd ? item.mask_byte[3:0] : item.mask_byte[7:4]);

	assign index = 32'(item.dy[15:0]) * 32'(CANVAS_W) + 32'(item.dx[15:0]);

	assign r6 = blend_chan({1'b0, item.src_color[15:11]}, {1'b0, item.dst_color[15:11]}, alpha);
	assign g = blend_chan(item.src_color[10:5], item.dst_color[10:5], alpha);
	assign b6 = blend_chan({1'b0, item.src_color[4:0]}, {1'b0, item.dst_color[4:0]}, alpha);
	assign r = r6[4:0];
	assign b = b6[4:0];

	always_comb begin
		res.write_enable = 1'b0;
		res.dst_addr = 16'd0;
		res.pixel = 16'd0;
		if (inside_x && inside_y && (alpha != ALPHA_CLEAR)) begin
			res.write_enable = 1'b1;
			res.dst_addr = index[15:0];
			res.pixel = (alpha == ALPHA_OPAQUE) ? item.src_color : {r, g, b};
		end
	end

endmodule
`default_nettype wire

@@ design/rgb565_masked_overlay_blend.sv @@
// Top level of the RGB565 masked overlay blender: stream ports, APB registers, two stages.
// Depends on rmob_pkg, rmob_regs, rmob_pos and rmob_blend.
//
// Overlay pixels enter row-major on the slave stream, each beat carrying the overlay
// color, its packed 4-bit mask byte and the canvas pixel it lands on. The block tracks
// the overlay column and row, offsets them by the signed origin, clips to the canvas,
// picks the alpha nibble by column parity when the mask is on, and blends each channel
// with a divide by 15. Every input beat gives exactly one output beat: the canvas address
// and new pixel, with tuser low when the pixel is clipped or fully transparent, and tlast
// on the final pixel of the overlay. One beat is accepted every clock while the output is
// not stalled; each beat is held in the input register and then in the result register
// around the blend logic. Program the registers only while no beat is in flight.
`default_nettype none
module rgb565_masked_overlay_blend #(
	parameter int CANVAS_W = rmob_pkg::CANVAS_W_DEF,
	parameter int CANVAS_H = rmob_pkg::CANVAS_H_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rmob_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [39:0]                 s_tdata,  // src_color, mask_byte, dst_color
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [31:0]                      m_tdata,  // dst_addr, pixel
	output logic [0:0]                       m_tuser,  // write_enable
	output logic                             m_tlast
);
	import rmob_pkg::*;

	cfg_t             cfg;
	logic             s_acc;
	logic             col_odd;
	logic [POS_W-1:0] dx;
	logic [POS_W-1:0] dy;
	logic             ovl_end;
	logic             ready_s2;

	logic             valid_s1;
	item_t            item_s1;
	result_t          res_comb;
	logic             valid_s2;
	result_t          res_s2;
	logic             last_s2;

	rmob_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rmob_pos u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (s_acc),
		.col_odd (col_odd),
		.dx      (dx),
		.dy      (dy),
		.ovl_end (ovl_end)
	);

	rmob_blend #(
		.CANVAS_W (CANVAS_W),
		.CANVAS_H (CANVAS_H)
	) u_blend (
		.item     (item_s1),
		.use_mask (cfg.use_mask),
		.res      (res_comb)
	);

	assign ready_s2 = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || ready_s2;
	assign s_acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_s1.src_color <= s_tdata[15:0];
			item_s1.mask_byte <= s_tdata[23:16];
			item_s1.dst_color <= s_tdata[39:24];
			item_s1.col_odd <= col_odd;
			item_s1.dx <= dx;
			item_s1.dy <= dy;
			item_s1.last <= ovl_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			res_s2 <= res_comb;
			last_s2 <= item_s1.last;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {res_s2.pixel, res_s2.dst_addr};
	assign m_tuser = res_s2.write_enable;
	assign m_tlast = last_s2;

endmodule
`default_nettype wire

@@ tb/rgb565_masked_overlay_blend_checker.sv @@
// Scoreboard for the RGB565 masked overlay blender: follows register writes and input beats,
// predicts every output beat and compares it field by field. Depends on rmob_pkg only.
`default_nettype none
module rgb565_masked_overlay_blend_checker #(
	parameter int CANVAS_W = rmob_pkg::CANVAS_W_DEF,
	parameter int CANVAS_H = rmob_pkg::CANVAS_H_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic                        pready,
	input  wire logic [rmob_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	input  wire logic                        s_tvalid,
	input  wire logic                        s_tready,
	input  wire logic [39:0]                 s_tdata,  // src_color, mask_byte, dst_color
	input  wire logic                        m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic [31:0]                 m_tdata,  // dst_addr, pixel
	input  wire logic [0:0]                  m_tuser,  // write_enable
	input  wire logic                        m_tlast,
	output int                               fail_count,
	output int                               pending,
	output int                               beats_checked,
	output int                               writes_checked,
	output int                               overlays_done
);
	import rmob_pkg::*;

	typedef struct packed {
		logic        write_enable;
		logic [15:0] dst_addr;
		logic [15:0] pixel;
		logic        last;
	} canvas_write_t;

	cfg_t            shadow;
	logic [15:0]     col_pos;
	logic [15:0]     row_pos;
	canvas_write_t   canvas_writes[$];
	int              mismatches = 0;

	function automatic int span(input logic [15:0] size);
		return (size == 16'd0) ? 1 : int'(size);
	endfunction

	function automatic int mix_channel(input int s, input int d, input int a);
		return (s * a + d * (int'(ALPHA_OPAQUE) - a)) / int'(ALPHA_OPAQUE);
	endfunction

	function automatic canvas_write_t predict_write(input logic [15:0] src,
		input logic [7:0] mask, input logic [15:0] dst);
		canvas_write_t r;
		int            x;
		int            y;
		logic [3:0]    alpha;
		x = int'($signed(shadow.origin_x)) + int'(col_pos);
		y = int'($signed(shadow.origin_y)) + int'(row_pos);
		r = '0;
		r.last = (int'(col_pos) + 1 >= span(shadow.overlay_width)) &&
			(int'(row_pos) + 1 >= span(shadow.overlay_height));
		alpha = ALPHA_OPAQUE;
		if (shadow.use_mask) begin
			alpha = col_pos[0] ? mask[3:0] : mask[7:4];
		end
		if (x >= 0 && x < CANVAS_W && y >= 0 && y < CANVAS_H && alpha != ALPHA_CLEAR) begin
			r.write_enable = 1'b1;
			r.dst_addr = 16'(y * CANVAS_W + x);
			if (alpha == ALPHA_OPAQUE) begin
				r.pixel = src;
			end else begin
				r.pixel = {5'(mix_channel(src[15:11], dst[15:11], alpha)),
					6'(mix_channel(src[10:5], dst[10:5], alpha)),
					5'(mix_channel(src[4:0], dst[4:0], alpha))};
			end
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input logic [15:0] want,
		input logic [15:0] got);
		$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		canvas_write_t want;
		canvas_write_t got;
		if (!arst_n) begin
			shadow <= '{origin_x: 16'd0, origin_y: 16'd0, overlay_width: 16'd1,
				overlay_height: 16'd1, use_mask: 1'b0};
			col_pos <= '0;
			row_pos <= '0;
			canvas_writes.delete();
			pending <= 0;
			fail_count <= 0;
			beats_checked <= 0;
			writes_checked <= 0;
			overlays_done <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.write_enable = m_tuser[0];
				got.dst_addr = m_tdata[15:0];
				got.pixel = m_tdata[31:16];
				got.last = m_tlast;
				beats_checked <= beats_checked + 1;
				if (got.write_enable === 1'b1) begin
					writes_checked <= writes_checked + 1;
				end
				if (got.last === 1'b1) begin
					overlays_done <= overlays_done + 1;
				end
				if (canvas_writes.size() == 0) begin
					$display("%0t: unexpected output beat, expected none, got we=%b addr=%h pixel=%h last=%b",
						$time, got.write_enable, got.dst_addr, got.pixel, got.last);
					mismatches++;
				end else begin
					want = canvas_writes.pop_front();
					if (got.write_enable !== want.write_enable) begin
						flag_mismatch("write_enable", 16'(want.write_enable), 16'(got.write_enable));
					end
					if (got.dst_addr !== want.dst_addr) begin
						flag_mismatch("dst_addr", want.dst_addr, got.dst_addr);
					end
					if (got.pixel !== want.pixel) begin
						flag_mismatch("pixel", want.pixel, got.pixel);
					end
					if (got.last !== want.last) begin
						flag_mismatch("last", 16'(want.last), 16'(got.last));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = predict_write(s_tdata[15:0], s_tdata[23:16], s_tdata[39:24]);
				canvas_writes.push_back(want);
				if (int'(col_pos) + 1 >= span(shadow.overlay_width)) begin
					col_pos <= '0;
					row_pos <= want.last ? 16'd0 : row_pos + 16'd1;
				end else begin
					col_pos <= col_pos + 16'd1;
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_ORIGIN_X: shadow.origin_x <= pwdata[15:0];
					REG_ORIGIN_Y: shadow.origin_y <= pwdata[15:0];
					REG_WIDTH: shadow.overlay_width <= pwdata[15:0];
					REG_HEIGHT: shadow.overlay_height <= pwdata[15:0];
					REG_USE_MASK: shadow.use_mask <= pwdata[0];
					default: ;
				endcase
			end
			pending <= canvas_writes.size();
			fail_count <= mismatches;
		end
	end

endmodule
`default_nettype wire

@@ tb/rgb565_masked_overlay_blend_tb.sv @@
// Testbench top for the RGB565 masked overlay blender: clock, reset, register programming,
// pixel stimulus with random gaps and output stalls. Depends on rmob_pkg, the block and its checker.
`default_nettype none
module rgb565_masked_overlay_blend_tb;
	import rmob_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PIXEL_TARGET = 550;
	localparam int DRAIN_CYCLES = 4;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic                s_tvalid = 1'b0;
	logic [39:0]         s_tdata = '0;
	logic                m_tready = 1'b0;
	wire logic [31:0]    prdata;
	wire logic           pready;
	wire logic           s_tready;
	wire logic           m_tvalid;
	wire logic [31:0]    m_tdata;
	wire logic [0:0]     m_tuser;
	wire logic           m_tlast;

	int fail_count;
	int pending;
	int beats_checked;
	int writes_checked;
	int overlays_done;
	int pixels_sent = 0;
	int settings_applied = 0;
	int idle_cycles = 0;
	bit source_burst = 1'b1;
	bit sink_burst = 1'b1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	rgb565_masked_overlay_blend u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	rgb565_masked_overlay_blend_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.fail_count     (fail_count),
		.pending        (pending),
		.beats_checked  (beats_checked),
		.writes_checked (writes_checked),
		.overlays_done  (overlays_done)
	);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d results outstanding", $time, idle_cycles,
				pending);
			$display("status: fail");
			$finish;
		end
	end

	initial begin : canvas_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = sink_burst ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	task automatic send_pixel(input logic [15:0] src, input logic [7:0] mask,
		input logic [15:0] dst);
		int gap;
		gap = source_burst ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dst, mask, src};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		pixels_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic program_overlay(input logic [15:0] ox, input logic [15:0] oy,
		input logic [15:0] w, input logic [15:0] h, input logic mask_on);
		wait_drained();
		write_reg(REG_ORIGIN_X, 32'(ox));
		write_reg(REG_ORIGIN_Y, 32'(oy));
		write_reg(REG_WIDTH, 32'(w));
		write_reg(REG_HEIGHT, 32'(h));
		write_reg(REG_USE_MASK, 32'(mask_on));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_applied++;
	endtask

	function automatic logic [15:0] pick_origin();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
			1: return 16'($urandom);
			default: return 16'($urandom_range(0, 300) - 40);
		endcase
	endfunction

	function automatic logic [15:0] pick_size(input int limit);
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 2))
				0: return 16'd0;
				1: return 16'd1;
				default: return 16'hFFFF;
			endcase
		end
		return 16'($urandom_range(1, limit));
	endfunction

	function automatic logic [7:0] pick_mask();
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 3))
				0: return 8'h00;
				1: return 8'hFF;
				2: return 8'hF0;
				default: return 8'h0F;
			endcase
		end
		return 8'($urandom);
	endfunction

	initial begin : stimulus
		logic [15:0] w;
		logic [15:0] h;
		int          count;
		int          area;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a single opaque pixel per overlay at the canvas origin.
		send_pixel(16'h0000, 8'h00, 16'hFFFF);
		send_pixel(16'hFFFF, 8'hFF, 16'h0000);

		// Left column clipped; alpha zero, one, mid values, fourteen and full from both nibbles.
		program_overlay(16'hFFFF, 16'd0, 16'd4, 16'd3, 1'b1);
		send_pixel(16'hFFFF, 8'hF0, 16'h0000);
		send_pixel(16'h1234, 8'h0F, 16'hABCD);
		send_pixel(16'hFFFF, 8'h0F, 16'h0000);
		send_pixel(16'hFFFF, 8'h80, 16'h0000);
		send_pixel(16'h0000, 8'hFF, 16'hFFFF);
		send_pixel(16'hFFFF, 8'hF1, 16'h0000);
		send_pixel(16'h0000, 8'h7F, 16'hFFFF);
		send_pixel(16'hF81F, 8'h1E, 16'h07E0);
		send_pixel(16'h5555, 8'hAA, 16'hAAAA);
		send_pixel(16'hFFFF, 8'h48, 16'hFFFF);
		send_pixel(16'h0000, 8'h3C, 16'h0000);
		send_pixel(16'hA5A5, 8'h5A, 16'h5A5A);

		// Right and bottom edges, highest address, and a mask byte that must be ignored.
		source_burst = 1'b0;
		sink_burst = 1'b0;
		program_overlay(16'd254, 16'd255, 16'd3, 16'd2, 1'b0);
		repeat (6) send_pixel(16'($urandom), 8'h00, 16'($urandom));

		// Origin extremes far off the canvas, with zero width and height acting as one.
		program_overlay(16'h7FFF, 16'h8000, 16'd0, 16'd0, 1'b1);
		send_pixel(16'hFFFF, 8'hFF, 16'hFFFF);
		send_pixel(16'h0000, 8'h00, 16'h0000);

		// Shrink the width while the column counter is already past the new size.
		program_overlay(16'd10, 16'd10, 16'd8, 16'd8, 1'b1);
		repeat (3) send_pixel(16'($urandom), pick_mask(), 16'($urandom));
		program_overlay(16'd10, 16'd10, 16'd2, 16'd2, 1'b1);
		repeat (3) send_pixel(16'($urandom), pick_mask(), 16'($urandom));

		while (pixels_sent < PIXEL_TARGET) begin
			source_burst = ($urandom_range(0, 3) == 0);
			sink_burst = ($urandom_range(0, 3) == 0);
			w = pick_size(16);
			h = pick_size(8);
			program_overlay(pick_origin(), pick_origin(), w, h, $urandom_range(0, 3) != 0);
			area = ((w == 16'd0) ? 1 : int'(w)) * ((h == 16'd0) ? 1 : int'(h));
			if (area <= 96 && $urandom_range(0, 3) != 0) begin
				count = area * $urandom_range(1, 2);
			end else begin
				count = $urandom_range(4, 48);
			end
			repeat (count) begin
				if ($urandom_range(0, 63) == 0) begin
					wait_drained();
				end
				send_pixel(16'($urandom), pick_mask(), 16'($urandom));
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Covered %0d pixels under %0d overlay settings: %0d results checked,",
			pixels_sent, settings_applied, beats_checked);
		$display("%0d canvas writes and %0d completed overlays; %0d mismatches.",
			writes_checked, overlays_done, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
